// ----- design/trbp_pkg.sv -----
// ----------------------------------------------------------------------------
// trbp_pkg
// Shared types and constants for the terminal ring buffer pair.
// ----------------------------------------------------------------------------
package trbp_pkg;

	localparam int RING_DEPTH_DEF = 128;

	localparam logic [7:0] LF_CODE = 8'h0A;
	localparam logic [7:0] CR_CODE = 8'h0D;

	localparam logic CR_BEFORE_LF_RST = 1'b1;

	typedef enum logic [2:0] {
		ACT_TX_PUT   = 3'd0,
		ACT_TX_DONE  = 3'd1,
		ACT_TX_FETCH = 3'd2,
		ACT_RX_BYTE  = 3'd3,
		ACT_RX_POP   = 3'd4,
		ACT_STATS    = 3'd5
	} action_t;

	typedef struct packed {
		action_t     action;
		logic [7:0]  data_byte;
		logic [6:0]  fetch_offset;
	} item_t;

	typedef struct packed {
		logic        valid;
		logic [6:0]  offset;
		logic [7:0]  length;
	} tx_start_t;

	typedef struct packed {
		logic tx_blocked;
		logic tx_written;
		logic tx_written_two;
		logic rx_dropped;
		logic rx_received;
	} stat_evt_t;

	typedef struct packed {
		logic [31:0] write_blocked;
		logic [31:0] written;
		logic [31:0] receive_dropped;
		logic [31:0] received;
	} stat_vals_t;

endpackage

// ----- design/trbp_tx_ring.sv -----
// ----------------------------------------------------------------------------
// trbp_tx_ring
// Transmit ring: byte queueing with optional CR insertion, chunk start and
// retire, and slot fetch for the sender.
// ----------------------------------------------------------------------------
module trbp_tx_ring #(
	parameter int RING_DEPTH = trbp_pkg::RING_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  trbp_pkg::item_t     item,
	input  logic                cr_before_lf,
	output logic                accepted,
	output trbp_pkg::tx_start_t start,
	output logic                rd_valid,
	output logic [7:0]          rd_byte,
	output trbp_pkg::stat_evt_t evt
);

	localparam int PW = $clog2(RING_DEPTH);
	localparam int HR = (RING_DEPTH + 1) / 2;
	localparam int RW = $clog2(HR);
	localparam bit ODD = (RING_DEPTH % 2) != 0;
	localparam logic [PW:0]   DEPTH_X   = (PW + 1)'(RING_DEPTH);
	localparam logic [PW-1:0] LAST_ADDR = PW'(RING_DEPTH - 1);

	function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] ptr, input logic [PW:0] k);
		logic [PW:0] sum;
		sum = {1'b0, ptr} + k;
		return (sum >= DEPTH_X) ? PW'(sum - DEPTH_X) : PW'(sum);
	endfunction

	logic [PW-1:0] head_q, tail_q, fill_q, infl_q;
	logic [PW-1:0] head_n, tail_n, fill_n, infl_n, infl_c, len;
	logic          need2, try_start;
	logic [PW:0]   need_x, fill_sum;

	logic          wr0_en, wr1_en;
	logic [PW-1:0] wr0_addr, wr1_addr;
	logic [7:0]    wr0_data, wr1_data;
	logic          w0_last, w1_last;

	// Two banks split by address parity; consecutive slots never share a bank,
	// so a CR/LF pair is written in the same cycle. With an odd depth the top
	// slot sits in a register of its own to keep the wrap pair apart as well.
	logic [7:0]    mem0 [HR];
	logic [7:0]    mem1 [HR];
	logic          b0_we, b1_we;
	logic [RW-1:0] b0_row, b1_row;
	logic [7:0]    b0_data, b1_data;

	logic [PW-1:0] r_addr;
	logic [7:0]    rd0_q, rd1_q;
	logic          rd_bank_q, rd_last_q;
	logic [7:0]    last_rd;

	always_comb begin
		head_n    = head_q;
		tail_n    = tail_q;
		fill_n    = fill_q;
		infl_n    = infl_q;
		wr0_en    = 1'b0;
		wr1_en    = 1'b0;
		accepted  = 1'b0;
		evt       = '0;
		try_start = 1'b0;
		rd_valid  = 1'b0;
		start     = '0;

		need2    = cr_before_lf && (item.data_byte == trbp_pkg::LF_CODE);
		need_x   = need2 ? (PW + 1)'(2) : (PW + 1)'(1);
		fill_sum = {1'b0, fill_q} + need_x;
		infl_c   = (infl_q > fill_q) ? fill_q : infl_q;

		wr0_addr = head_q;
		wr1_addr = wrap_inc(head_q, (PW + 1)'(1));
		wr0_data = need2 ? trbp_pkg::CR_CODE : item.data_byte;
		wr1_data = item.data_byte;

		case (item.action)
			trbp_pkg::ACT_TX_PUT: begin
				if (fill_sum >= DEPTH_X) begin
					evt.tx_blocked = 1'b1;
				end else begin
					wr0_en             = 1'b1;
					wr1_en             = need2;
					head_n             = wrap_inc(head_q, need_x);
					fill_n             = PW'(fill_sum);
					accepted           = 1'b1;
					evt.tx_written     = 1'b1;
					evt.tx_written_two = need2;
					try_start          = 1'b1;
				end
			end
			trbp_pkg::ACT_TX_DONE: begin
				tail_n    = wrap_inc(tail_q, {1'b0, infl_c});
				fill_n    = fill_q - infl_c;
				infl_n    = '0;
				try_start = 1'b1;
			end
			trbp_pkg::ACT_TX_FETCH: begin
				rd_valid = int'(item.fetch_offset) < RING_DEPTH;
			end
			default: ;
		endcase

		// chunk runs to the ring end at most
		len = fill_n;
		if (({1'b0, fill_n} + {1'b0, tail_n}) >= DEPTH_X)
			len = PW'(DEPTH_X - {1'b0, tail_n});
		if (try_start && (infl_n == '0) && (fill_n != '0)) begin
			infl_n       = len;
			start.valid  = 1'b1;
			start.offset = 7'(tail_n);
			start.length = 8'(len);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
			infl_q <= '0;
		end else if (fire) begin
			head_q <= head_n;
			tail_q <= tail_n;
			fill_q <= fill_n;
			infl_q <= infl_n;
		end
	end

	assign w0_last = ODD && (wr0_addr == LAST_ADDR);
	assign w1_last = ODD && (wr1_addr == LAST_ADDR);

	always_comb begin
		b0_we   = 1'b0;
		b0_row  = RW'(wr0_addr >> 1);
		b0_data = wr0_data;
		b1_we   = 1'b0;
		b1_row  = RW'(wr0_addr >> 1);
		b1_data = wr0_data;
		if (fire && wr0_en && !w0_last && !wr0_addr[0]) begin
			b0_we = 1'b1;
		end else if (fire && wr1_en && !w1_last && !wr1_addr[0]) begin
			b0_we   = 1'b1;
			b0_row  = RW'(wr1_addr >> 1);
			b0_data = wr1_data;
		end
		if (fire && wr0_en && !w0_last && wr0_addr[0]) begin
			b1_we = 1'b1;
		end else if (fire && wr1_en && !w1_last && wr1_addr[0]) begin
			b1_we   = 1'b1;
			b1_row  = RW'(wr1_addr >> 1);
			b1_data = wr1_data;
		end
	end

	always_ff @(posedge clk) begin
		if (b0_we)
			mem0[b0_row] <= b0_data;
	end

	always_ff @(posedge clk) begin
		if (b1_we)
			mem1[b1_row] <= b1_data;
	end

	assign r_addr = PW'(item.fetch_offset);

	always_ff @(posedge clk) begin
		if (fire && (item.action == trbp_pkg::ACT_TX_FETCH)) begin
			rd0_q     <= mem0[RW'(r_addr >> 1)];
			rd1_q     <= mem1[RW'(r_addr >> 1)];
			rd_bank_q <= r_addr[0];
			rd_last_q <= ODD && (r_addr == LAST_ADDR);
		end
	end

	generate
		if (ODD) begin : g_odd
			logic [7:0] slot_q;
			logic [7:0] slot_rd_q;

			always_ff @(posedge clk) begin
				if (fire && wr0_en && w0_last)
					slot_q <= wr0_data;
				else if (fire && wr1_en && w1_last)
					slot_q <= wr1_data;
			end

			always_ff @(posedge clk) begin
				if (fire && (item.action == trbp_pkg::ACT_TX_FETCH))
					slot_rd_q <= slot_q;
			end

			assign last_rd = slot_rd_q;
		end else begin : g_even
			assign last_rd = 8'h00;
		end
	endgenerate

	assign rd_byte = rd_last_q ? last_rd : (rd_bank_q ? rd1_q : rd0_q);

endmodule

// ----- design/trbp_rx_ring.sv -----
// ----------------------------------------------------------------------------
// trbp_rx_ring
// Receive ring: stores incoming bytes while room remains, pops in order.
// ----------------------------------------------------------------------------
module trbp_rx_ring #(
	parameter int RING_DEPTH = trbp_pkg::RING_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  trbp_pkg::item_t     item,
	output logic                accepted,
	output logic                rd_valid,
	output logic [7:0]          rd_byte,
	output trbp_pkg::stat_evt_t evt
);

	localparam int PW = $clog2(RING_DEPTH);
	localparam logic [PW-1:0] LAST_ADDR = PW'(RING_DEPTH - 1);

	function automatic logic [PW-1:0] wrap_inc1(input logic [PW-1:0] ptr);
		return (ptr == LAST_ADDR) ? '0 : ptr + PW'(1);
	endfunction

	logic [PW-1:0] head_q, tail_q, fill_q;
	logic [PW-1:0] head_n, tail_n, fill_n;
	logic          wr_en;
	logic [7:0]    mem [RING_DEPTH];
	logic [7:0]    rd_q;

	always_comb begin
		head_n   = head_q;
		tail_n   = tail_q;
		fill_n   = fill_q;
		wr_en    = 1'b0;
		accepted = 1'b0;
		rd_valid = 1'b0;
		evt      = '0;
		case (item.action)
			trbp_pkg::ACT_RX_BYTE: begin
				// at most depth minus one bytes held
				if (fill_q != LAST_ADDR) begin
					wr_en           = 1'b1;
					head_n          = wrap_inc1(head_q);
					fill_n          = fill_q + PW'(1);
					accepted        = 1'b1;
					evt.rx_received = 1'b1;
				end else begin
					evt.rx_dropped = 1'b1;
				end
			end
			trbp_pkg::ACT_RX_POP: begin
				if (fill_q != '0) begin
					rd_valid = 1'b1;
					tail_n   = wrap_inc1(tail_q);
					fill_n   = fill_q - PW'(1);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
		end else if (fire) begin
			head_q <= head_n;
			tail_q <= tail_n;
			fill_q <= fill_n;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && wr_en)
			mem[head_q] <= item.data_byte;
	end

	always_ff @(posedge clk) begin
		if (fire && (item.action == trbp_pkg::ACT_RX_POP))
			rd_q <= mem[tail_q];
	end

	assign rd_byte = rd_q;

endmodule

// ----- design/trbp_stats.sv -----
// ----------------------------------------------------------------------------
// trbp_stats
// Four wrapping 32-bit event counters, read and cleared in one beat.
// ----------------------------------------------------------------------------
module trbp_stats (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  logic                 clear,
	input  trbp_pkg::stat_evt_t  evt,
	output trbp_pkg::stat_vals_t vals
);

	trbp_pkg::stat_vals_t cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (fire) begin
			if (clear) begin
				cnt_q <= '0;
			end else begin
				cnt_q.write_blocked   <= cnt_q.write_blocked + 32'(evt.tx_blocked);
				cnt_q.written         <= cnt_q.written + 32'(evt.tx_written)
					+ 32'(evt.tx_written_two);
				cnt_q.receive_dropped <= cnt_q.receive_dropped + 32'(evt.rx_dropped);
				cnt_q.received        <= cnt_q.received + 32'(evt.rx_received);
			end
		end
	end

	assign vals = cnt_q;

endmodule

// ----- design/terminal_ring_buffer_pair_core.sv -----
// ----------------------------------------------------------------------------
// terminal_ring_buffer_pair_core
// Transmit and receive byte rings for a terminal link, with event counters.
// ----------------------------------------------------------------------------
// Usage: one input beat (action, data_byte, fetch_offset) is taken when
// in_valid is high and in_stall is low; each input beat gives exactly one
// output beat, taken when out_valid is high and out_stall is low.
// Actions: tx put, tx done, tx fetch, rx byte, rx pop, stats read-clear.
// Each beat passes an input register, then the ring update and memory read
// land in the result register that drives the output beat.
// One beat per cycle unless stalled; each beat touches one memory port per
// ring (the tx ring writes a CR/LF pair at once across its two banks).
// When the receiver stalls, the result register holds and in_stall rises
// once the input register is also full; no beat is lost or repeated.
// cfg_wr_en/cfg_wr_data set cr_before_lf; write it only while idle.
// Reset clears both rings, the counters, and sets cr_before_lf to 1.
// Ring contents are not cleared; a fetch of a never-written tx slot is
// undefined.
// ----------------------------------------------------------------------------
module terminal_ring_buffer_pair_core #(
	parameter int RING_DEPTH = trbp_pkg::RING_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  action,
	input  logic [7:0]  data_byte,
	input  logic [6:0]  fetch_offset,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        accepted,
	output logic        start_valid,
	output logic [6:0]  start_offset,
	output logic [7:0]  start_length,
	output logic [7:0]  read_byte,
	output logic        read_valid,
	output logic [31:0] count_write_blocked,
	output logic [31:0] count_written,
	output logic [31:0] count_receive_dropped,
	output logic [31:0] count_received
);

	logic                 cr_q;
	logic                 valid_s1;
	trbp_pkg::item_t      item_s1;
	logic                 valid_s2;
	logic                 accepted_s2;
	trbp_pkg::tx_start_t  start_s2;
	logic                 read_valid_s2;
	logic                 read_rx_s2;
	trbp_pkg::stat_vals_t counts_s2;

	logic                 s2_ready, fire, in_take;
	logic                 tx_acc, rx_acc, tx_rd_valid, rx_rd_valid;
	logic [7:0]           tx_rd_byte, rx_rd_byte;
	trbp_pkg::tx_start_t  tx_start;
	trbp_pkg::stat_evt_t  tx_evt, rx_evt, evt;
	trbp_pkg::stat_vals_t stat_vals;
	logic                 is_stats;

	assign s2_ready = !valid_s2 || !out_stall;
	assign fire     = valid_s1 && s2_ready;
	assign in_stall = valid_s1 && !s2_ready;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cr_q <= trbp_pkg::CR_BEFORE_LF_RST;
		else if (cfg_wr_en)
			cr_q <= cfg_wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_take)
			valid_s1 <= 1'b1;
		else if (fire)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.action       <= trbp_pkg::action_t'(action);
			item_s1.data_byte    <= data_byte;
			item_s1.fetch_offset <= fetch_offset;
		end
	end

	trbp_tx_ring #(.RING_DEPTH(RING_DEPTH)) u_tx (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.item        (item_s1),
		.cr_before_lf(cr_q),
		.accepted    (tx_acc),
		.start       (tx_start),
		.rd_valid    (tx_rd_valid),
		.rd_byte     (tx_rd_byte),
		.evt         (tx_evt)
	);

	trbp_rx_ring #(.RING_DEPTH(RING_DEPTH)) u_rx (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.item     (item_s1),
		.accepted (rx_acc),
		.rd_valid (rx_rd_valid),
		.rd_byte  (rx_rd_byte),
		.evt      (rx_evt)
	);

	assign evt      = tx_evt | rx_evt;
	assign is_stats = item_s1.action == trbp_pkg::ACT_STATS;

	trbp_stats u_stats (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.clear  (is_stats),
		.evt    (evt),
		.vals   (stat_vals)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (s2_ready)
			valid_s2 <= fire;
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			accepted_s2   <= tx_acc | rx_acc;
			start_s2      <= tx_start;
			read_valid_s2 <= tx_rd_valid | rx_rd_valid;
			read_rx_s2    <= rx_rd_valid;
			counts_s2     <= is_stats ? stat_vals : '0;
		end
	end

	assign out_valid             = valid_s2;
	assign accepted              = accepted_s2;
	assign start_valid           = start_s2.valid;
	assign start_offset          = start_s2.offset;
	assign start_length          = start_s2.length;
	assign read_valid            = read_valid_s2;
	assign read_byte             = !read_valid_s2 ? 8'h00 :
		(read_rx_s2 ? rx_rd_byte : tx_rd_byte);
	assign count_write_blocked   = counts_s2.write_blocked;
	assign count_written         = counts_s2.written;
	assign count_receive_dropped = counts_s2.receive_dropped;
	assign count_received        = counts_s2.received;

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for terminal_ring_buffer_pair_core. A queue of terminal
// events feeds a falling-edge driver; a rising-edge monitor predicts each
// accepted beat with a local copy of both rings and the counters, and checks
// every result beat field by field, in order. Both sides idle at random.
// ----------------------------------------------------------------------------
module testbench;
	import trbp_pkg::*;

	localparam int DEPTH = RING_DEPTH_DEF;
	localparam int STALL_LIMIT = 600;
	localparam logic [2:0] ACT_SPARE6 = 3'd6;
	localparam logic [2:0] ACT_SPARE7 = 3'd7;

	typedef struct packed {
		logic        accepted;
		tx_start_t   start;
		logic [7:0]  read_byte;
		logic        read_valid;
		stat_vals_t  counts;
	} ring_result_t;

	typedef struct {
		logic [2:0] act;
		logic [7:0] b;
		logic [6:0] off;
		bit         drain_first;
	} term_event_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  action = ACT_SPARE6;
	logic [7:0]  data_byte = 8'h00;
	logic [6:0]  fetch_offset = 7'd0;
	logic        cfg_wr_en = 1'b0;
	logic        cfg_wr_data = 1'b1;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        accepted;
	logic        start_valid;
	logic [6:0]  start_offset;
	logic [7:0]  start_length;
	logic [7:0]  read_byte;
	logic        read_valid;
	logic [31:0] count_write_blocked;
	logic [31:0] count_written;
	logic [31:0] count_receive_dropped;
	logic [31:0] count_received;

	terminal_ring_buffer_pair_core u_dut (
		.clk                   (clk),
		.arst_n                (arst_n),
		.in_valid              (in_valid),
		.in_stall              (in_stall),
		.action                (action),
		.data_byte             (data_byte),
		.fetch_offset          (fetch_offset),
		.cfg_wr_en             (cfg_wr_en),
		.cfg_wr_data           (cfg_wr_data),
		.out_valid             (out_valid),
		.out_stall             (out_stall),
		.accepted              (accepted),
		.start_valid           (start_valid),
		.start_offset          (start_offset),
		.start_length          (start_length),
		.read_byte             (read_byte),
		.read_valid            (read_valid),
		.count_write_blocked   (count_write_blocked),
		.count_written         (count_written),
		.count_receive_dropped (count_receive_dropped),
		.count_received        (count_received)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---- shadow state of the two rings ----
	logic [7:0]  tx_mem [DEPTH];
	bit          tx_written [DEPTH];
	logic [6:0]  tx_head, tx_tail;
	logic [7:0]  tx_fill, tx_inflight;
	logic [7:0]  rx_mem [DEPTH];
	logic [6:0]  rx_head, rx_tail;
	logic [7:0]  rx_fill;
	logic [31:0] cnt_blocked, cnt_written, cnt_dropped, cnt_received;
	logic        crlf_on = CR_BEFORE_LF_RST;

	term_event_t  term_events[$];
	ring_result_t ring_results_due[$];

	bit in_beat_taken = 1'b0;
	int errors = 0;
	int beats_in = 0;
	int beats_out = 0;
	int puts_refused = 0;
	int rx_drops = 0;
	int chunks_started = 0;
	int gap_in = 0, quiet_in = 0, stall_left = 0, quiet_out = 0;

	initial begin
		for (int i = 0; i < DEPTH; i++)
			tx_written[i] = 1'b0;
		tx_head = '0; tx_tail = '0; tx_fill = '0; tx_inflight = '0;
		rx_head = '0; rx_tail = '0; rx_fill = '0;
		cnt_blocked = '0; cnt_written = '0; cnt_dropped = '0; cnt_received = '0;
	end

	function automatic void tx_push(logic [7:0] b);
		tx_mem[tx_head] = b;
		tx_written[tx_head] = 1'b1;
		tx_head = tx_head + 7'd1;
		tx_fill = tx_fill + 8'd1;
	endfunction

	// open a new chunk when the link is idle and bytes are waiting
	function automatic void tx_kick(inout ring_result_t r);
		int len;
		if (tx_inflight == 0 && tx_fill != 0) begin
			len = int'(tx_fill);
			if (len + tx_tail >= DEPTH)
				len = DEPTH - tx_tail;
			tx_inflight = len[7:0];
			r.start.valid = 1'b1;
			r.start.offset = tx_tail;
			r.start.length = len[7:0];
			chunks_started++;
		end
	endfunction

	function automatic ring_result_t ring_pair_step(logic [2:0] act, logic [7:0] b,
			logic [6:0] off);
		ring_result_t r;
		int need;
		r = '0;
		case (act)
			ACT_TX_PUT: begin
				need = (crlf_on && b == LF_CODE) ? 2 : 1;
				if (tx_fill + need >= DEPTH) begin
					cnt_blocked = cnt_blocked + 32'd1;
					puts_refused++;
				end else begin
					if (need == 2)
						tx_push(CR_CODE);
					tx_push(b);
					cnt_written = cnt_written + need;
					r.accepted = 1'b1;
					tx_kick(r);
				end
			end
			ACT_TX_DONE: begin
				if (tx_inflight > tx_fill)
					tx_inflight = tx_fill;
				tx_tail = tx_tail + tx_inflight[6:0];
				tx_fill = tx_fill - tx_inflight;
				tx_inflight = '0;
				tx_kick(r);
			end
			ACT_TX_FETCH: begin
				r.read_byte = tx_mem[off];
				r.read_valid = 1'b1;
			end
			ACT_RX_BYTE: begin
				if (rx_fill + 1 < DEPTH) begin
					rx_mem[rx_head] = b;
					rx_head = rx_head + 7'd1;
					rx_fill = rx_fill + 8'd1;
					cnt_received = cnt_received + 32'd1;
					r.accepted = 1'b1;
				end else begin
					cnt_dropped = cnt_dropped + 32'd1;
					rx_drops++;
				end
			end
			ACT_RX_POP: begin
				if (rx_fill != 0) begin
					r.read_byte = rx_mem[rx_tail];
					r.read_valid = 1'b1;
					rx_tail = rx_tail + 7'd1;
					rx_fill = rx_fill - 8'd1;
				end
			end
			ACT_STATS: begin
				r.counts.write_blocked = cnt_blocked;
				r.counts.written = cnt_written;
				r.counts.receive_dropped = cnt_dropped;
				r.counts.received = cnt_received;
				cnt_blocked = '0; cnt_written = '0; cnt_dropped = '0; cnt_received = '0;
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic flag_error(string msg);
		errors++;
		if (errors <= 10)
			$display("mismatch: %s", msg);
	endtask

	task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
		if (got !== want)
			flag_error($sformatf("result %0d %s expected %0h got %0h", beats_out, field,
				want, got));
	endtask

	// ---- monitor: prediction on input beats, checking on output beats ----
	always @(posedge clk) begin
		ring_result_t want;
		if (arst_n) begin
			if (cfg_wr_en)
				crlf_on = cfg_wr_data;
			in_beat_taken = in_valid && !in_stall;
			if (in_beat_taken) begin
				ring_results_due.push_back(ring_pair_step(action, data_byte, fetch_offset));
				beats_in++;
			end
			if (out_valid && !out_stall) begin
				if (ring_results_due.size() == 0) begin
					flag_error($sformatf("result beat with nothing outstanding, read_byte %0h",
						read_byte));
				end else begin
					want = ring_results_due.pop_front();
					check_field("accepted", want.accepted, accepted);
					check_field("start_valid", want.start.valid, start_valid);
					check_field("start_offset", want.start.offset, start_offset);
					check_field("start_length", want.start.length, start_length);
					check_field("read_byte", want.read_byte, read_byte);
					check_field("read_valid", want.read_valid, read_valid);
					check_field("count_write_blocked", want.counts.write_blocked,
						count_write_blocked);
					check_field("count_written", want.counts.written, count_written);
					check_field("count_receive_dropped", want.counts.receive_dropped,
						count_receive_dropped);
					check_field("count_received", want.counts.received, count_received);
				end
				beats_out++;
			end
		end
	end

	// ---- watchdog: no beat on either side for too long ----
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d results outstanding",
				idle_cycles, ring_results_due.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	// mostly back-to-back, some short gaps, a few long ones
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	// ---- driver: input beats and result-side stall ----
	always @(negedge clk) begin
		term_event_t ev;
		int slot;
		logic nxt_valid;
		logic nxt_stall;
		nxt_valid = 1'b0;
		nxt_stall = 1'b0;
		if (arst_n) begin
			nxt_valid = in_valid;
			if (!in_valid || in_beat_taken) begin
				if (quiet_in > 0)
					quiet_in--;
				else if ($urandom_range(0, 149) == 0)
					quiet_in = $urandom_range(30, 90);
				nxt_valid = 1'b0;
				if (gap_in > 0) begin
					gap_in--;
				end else if (term_events.size() != 0 &&
						!(term_events[0].drain_first && ring_results_due.size() != 0)) begin
					ev = term_events.pop_front();
					// fetches only ever hit slots that have been written
					if (ev.act == ACT_TX_FETCH) begin
						slot = -1;
						for (int k = 0; k < DEPTH && slot < 0; k++)
							if (tx_written[(ev.off + k) % DEPTH])
								slot = (ev.off + k) % DEPTH;
						if (slot < 0)
							ev.act = ACT_SPARE6;
						else
							ev.off = slot[6:0];
					end
					action <= ev.act;
					data_byte <= ev.b;
					fetch_offset <= ev.off;
					nxt_valid = 1'b1;
					gap_in = (quiet_in > 0) ? 0 : idle_len();
				end
			end
			if (quiet_out > 0)
				quiet_out--;
			else if ($urandom_range(0, 149) == 0)
				quiet_out = $urandom_range(30, 90);
			if (stall_left > 0) begin
				stall_left--;
				nxt_stall = 1'b1;
			end else begin
				stall_left = (quiet_out > 0) ? 0 : idle_len();
			end
		end
		in_valid <= nxt_valid;
		out_stall <= nxt_stall;
	end

	// ---- stimulus ----
	task automatic add_event(logic [2:0] act, logic [7:0] b, logic [6:0] off,
			bit drain = 1'b0);
		term_event_t ev;
		ev.act = act;
		ev.b = b;
		ev.off = off;
		ev.drain_first = drain;
		term_events.push_back(ev);
	endtask

	function automatic logic [7:0] any_byte();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 5) == 0)
			b = LF_CODE;
		return b;
	endfunction

	function automatic logic [6:0] any_off();
		return 7'($urandom_range(0, DEPTH - 1));
	endfunction

	task automatic add_mixed(int n);
		logic [2:0] act;
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 34)
				act = ACT_TX_PUT;
			else if (r < 46)
				act = ACT_TX_DONE;
			else if (r < 58)
				act = ACT_TX_FETCH;
			else if (r < 76)
				act = ACT_RX_BYTE;
			else if (r < 90)
				act = ACT_RX_POP;
			else if (r < 96)
				act = ACT_STATS;
			else
				act = $urandom_range(0, 1) ? ACT_SPARE6 : ACT_SPARE7;
			add_event(act, any_byte(), any_off(), $urandom_range(0, 39) == 0);
		end
	endtask

	// Fill the tx ring to the brim with CR insertion on: ends at 126 queued so
	// that an LF pair is refused, one plain byte still fits, then nothing does.
	task automatic add_tx_fill();
		int fill;
		logic [7:0] b;
		repeat (3)
			add_event(ACT_TX_DONE, any_byte(), any_off());
		fill = 0;
		while (fill < 124) begin
			b = ($urandom_range(0, 7) == 0) ? LF_CODE : 8'($urandom_range(0, 255));
			fill += (b == LF_CODE) ? 2 : 1;
			add_event(ACT_TX_PUT, b, any_off());
		end
		while (fill < 126) begin
			add_event(ACT_TX_PUT, 8'h41, any_off());
			fill++;
		end
		add_event(ACT_TX_PUT, LF_CODE, any_off());
		add_event(ACT_TX_PUT, 8'h7E, any_off());
		add_event(ACT_TX_PUT, 8'h20, any_off());
		add_event(ACT_TX_PUT, LF_CODE, any_off());
		add_event(ACT_TX_DONE, any_byte(), any_off());
		repeat (4)
			add_event(ACT_TX_FETCH, any_byte(), any_off());
		add_event(ACT_TX_DONE, any_byte(), any_off());
		add_event(ACT_TX_DONE, any_byte(), any_off(), 1'b1);
	endtask

	// overrun the rx ring, then pop it dry and past empty
	task automatic add_rx_fill();
		repeat (132)
			add_event(ACT_RX_BYTE, 8'($urandom_range(0, 255)), any_off());
		add_event(ACT_STATS, any_byte(), any_off());
		repeat (140)
			add_event(ACT_RX_POP, any_byte(), any_off());
	endtask

	task automatic add_directed();
		add_event(ACT_STATS, 8'h00, 7'd0);
		add_event(ACT_RX_POP, 8'h00, 7'd0);
		add_event(ACT_TX_DONE, 8'h00, 7'd0);        // nothing in flight, nothing queued
		add_event(ACT_TX_PUT, 8'h00, 7'd0);
		add_event(ACT_TX_PUT, 8'hFF, 7'd127);
		add_event(ACT_TX_PUT, LF_CODE, 7'd0);       // queued as CR, LF
		add_event(ACT_TX_FETCH, 8'hFF, 7'd0);
		add_event(ACT_TX_FETCH, 8'h00, 7'd3);
		add_event(ACT_TX_DONE, 8'h00, 7'd0);
		add_event(ACT_TX_DONE, 8'h00, 7'd0);
		add_event(ACT_TX_DONE, 8'h00, 7'd0);
		add_event(ACT_RX_BYTE, 8'h00, 7'd0);
		add_event(ACT_RX_BYTE, 8'hFF, 7'd127);
		add_event(ACT_RX_BYTE, LF_CODE, 7'd0);
		repeat (4)
			add_event(ACT_RX_POP, 8'h00, 7'd0);
		add_event(ACT_SPARE6, 8'hFF, 7'd127);
		add_event(ACT_SPARE7, 8'h00, 7'd0);
		add_event(ACT_STATS, 8'h00, 7'd0, 1'b1);
	endtask

	// wait until the block is idle: nothing to send, nothing outstanding
	task automatic settle();
		do
			@(negedge clk);
		while (term_events.size() != 0 || in_valid || ring_results_due.size() != 0);
		repeat (4)
			@(negedge clk);
	endtask

	task automatic set_crlf(logic v);
		settle();
		cfg_wr_data <= v;
		cfg_wr_en <= 1'b1;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		repeat (6)
			@(negedge clk);
		arst_n = 1'b1;

		set_crlf(1'b1);
		add_directed();
		add_tx_fill();
		add_mixed(70);

		set_crlf(1'b0);
		add_mixed(35);
		add_rx_fill();
		add_mixed(35);

		set_crlf(1'b1);
		add_mixed(70);

		set_crlf(1'b0);
		add_mixed(70);

		settle();
		repeat (6)
			@(negedge clk);
		$display("covered %0d beats in, %0d results out, cr_before_lf at 0 and 1", beats_in,
			beats_out);
		$display("tx chunks started %0d, puts refused %0d, rx bytes dropped %0d",
			chunks_started, puts_refused, rx_drops);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- files.f -----
design/trbp_pkg.sv
design/trbp_tx_ring.sv
design/trbp_rx_ring.sv
design/trbp_stats.sv
design/terminal_ring_buffer_pair_core.sv
test/testbench.sv
